// ===== hdl/ixs_pkg.sv =====
`default_nettype none

package ixs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_W    = 32;
  localparam int POS_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_key;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_position;
  } out_item_t;

  // Contents of one sort cell
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        pos;
  } cell_data_t;

  // Chain-wide control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ixs_cell.sv =====
`default_nettype none

module ixs_cell (
  input  wire                           clk,
  input  ixs_pkg::cell_ctl_t            ctl,
  input  wire signed [ixs_pkg::KEY_W-1:0] new_key,
  input  ixs_pkg::cell_data_t           new_data,
  input  wire                           occupied,
  input  wire                           left_ins,
  input  ixs_pkg::cell_data_t           left_data,
  input  ixs_pkg::cell_data_t           right_data,
  output ixs_pkg::cell_data_t           data,
  output logic                          ins
);
  import ixs_pkg::*;

  // Strictly greater keeps equal keys ahead of the newcomer
  assign ins = !occupied || (data.key > new_key);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (ins && !left_ins) begin
        data <= new_data;
      end else if (ins && left_ins) begin
        data <= left_data;
      end
    end else if (ctl.drain) begin
      data <= right_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/index_sort_core.sv =====
// Timing: a key is sorted in at the edge that transfers it; busy stays low, so one key per cycle.
// A key flagged last raises busy while the n held keys (n = 1..MAX_KEYS) are drained;
// the drain flag registers at that transfer; the result register then gives one per cycle.
// Throughput: one key per cycle while loading, one position per cycle while draining.
// Reset (rst, synchronous): empties the set, drops any drain in progress, clears strobe.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
`default_nettype none

module index_sort_core (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  ixs_pkg::in_item_t  item,
  output logic               strobe,
  output ixs_pkg::out_item_t result
);
  import ixs_pkg::*;

  // Chain of insertion cells: cell 0 holds the smallest key. On a transfer every
  // cell compares its key with the incoming one; the first cell that is empty or
  // larger takes the new key and every cell to its right takes its left neighbor,
  // if the chain has room. On drain the whole chain moves one step toward cell 0 each cycle.

  logic [CNT_W-1:0] fill;
  logic             draining;
  logic [CNT_W-1:0] remaining;

  logic       accept;
  logic       store_en;
  cell_ctl_t  ctl;
  cell_data_t new_data;

  cell_data_t          cell_q     [MAX_KEYS];
  cell_data_t          left_data  [MAX_KEYS];
  cell_data_t          right_data [MAX_KEYS];
  logic [MAX_KEYS-1:0] ins_vec;
  logic [MAX_KEYS-1:0] left_ins;
  logic [MAX_KEYS-1:0] occupied;

  assign busy     = draining;
  assign accept   = start && !busy;
  // Drop keys once the chain is full
  assign store_en = accept && (fill != CNT_W'(MAX_KEYS));

  assign ctl.insert = store_en;
  assign ctl.drain  = draining;

  assign new_data.key = item.key;
  assign new_data.pos = fill[POS_W-1:0];

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_chain
    assign occupied[i] = CNT_W'(i) < fill;

    if (i == 0) begin : g_first
      assign left_ins[i]  = 1'b0;
      assign left_data[i] = new_data;
    end else begin : g_inner
      assign left_ins[i]  = ins_vec[i-1];
      assign left_data[i] = cell_q[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_last
      assign right_data[i] = cell_q[i];
    end else begin : g_mid
      assign right_data[i] = cell_q[i+1];
    end

    ixs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_key    (item.key),
      .new_data   (new_data),
      .occupied   (occupied[i]),
      .left_ins   (left_ins[i]),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .data       (cell_q[i]),
      .ins        (ins_vec[i])
    );
  end

  // Fill count and drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      draining  <= 1'b0;
      remaining <= '0;
    end else if (draining) begin
      remaining <= remaining - CNT_W'(1);
      if (remaining == CNT_W'(1)) begin
        draining <= 1'b0;
        fill     <= '0;
      end
    end else if (accept) begin
      if (store_en) begin
        fill <= fill + CNT_W'(1);
      end
      if (item.last_key) begin
        draining  <= 1'b1;
        // The closing key counts too when there was room for it
        remaining <= store_en ? fill + CNT_W'(1) : fill;
      end
    end
  end

  // Result register: one transfer per cycle while draining, taken from the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= draining;
    end
  end

  always_ff @(posedge clk) begin
    if (draining) begin
      result.position      <= cell_q[0].pos;
      result.last_position <= (remaining == CNT_W'(1));
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ixs_checker.sv =====
`default_nettype none

module ixs_checker (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input ixs_pkg::in_item_t  item,
  input wire                strobe,
  input ixs_pkg::out_item_t result
);
  import ixs_pkg::*;

  // A result only follows a cycle of draining
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A closing key starts the drain
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_key) |=> busy)
    else $error("closing key did not start the drain");

  // A plain key is absorbed without results
  a_plain_key_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last_key) |=> (!busy && !strobe))
    else $error("plain key produced activity");

  // Results of one run come back to back until the flagged one
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last_position) |=> strobe)
    else $error("gap inside a sorted run");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_position) |=> !strobe)
    else $error("result after the final position");

endmodule

bind index_sort_core ixs_checker u_ixs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ixs_pkg::*;

  // Scoreboard: keeps its own copy of the key set. Sort each accepted key into
  // place by stable insertion, and queue the sorted positions when the set closes.
  class argsort_ledger;
    logic signed [KEY_W-1:0] held_keys[MAX_KEYS];
    logic [POS_W-1:0]        sorted_pos[MAX_KEYS];
    int unsigned             held;
    out_item_t               due[$];
    int unsigned             errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_key(in_item_t it);
      int        slot;
      out_item_t r;
      // Drop keys that arrive while the set is full; a dropped key can still close it.
      if (held < MAX_KEYS) begin
        held_keys[held] = it.key;
        slot = held;
        // Shift strictly larger keys up; equal keys stay ahead of the newcomer.
        while (slot > 0 && $signed(held_keys[sorted_pos[slot-1]]) > $signed(it.key)) begin
          sorted_pos[slot] = sorted_pos[slot-1];
          slot--;
        end
        sorted_pos[slot] = POS_W'(held);
        held++;
      end
      if (it.last_key) begin
        for (int i = 0; i < held; i++) begin
          r.position      = sorted_pos[i];
          r.last_position = (i == held - 1);
          due.push_back(r);
        end
        held = 0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual position %0d last %0b",
                 $time, got.position, got.last_position);
        errors++;
      end else begin
        exp = due.pop_front();
        if (got.position !== exp.position) begin
          $display("%0t: position mismatch, expected %0d, actual %0d",
                   $time, exp.position, got.position);
          errors++;
        end
        if (got.last_position !== exp.last_position) begin
          $display("%0t: last_position mismatch, expected %0b, actual %0b",
                   $time, exp.last_position, got.last_position);
          errors++;
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item = '0;
  logic      strobe;
  out_item_t result;

  argsort_ledger ledger = new();
  int unsigned   sent = 0;

  index_sort_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // Results cannot be held off: check every strobe at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && strobe) ledger.check_result(result);
  end

  // Offer one key and hold it until a transfer happens (start high, busy low at an edge).
  // Afterwards, sometimes drop start for a random gap, except in the quiet stretch.
  task automatic send_key(input logic signed [KEY_W-1:0] k, input logic lst);
    in_item_t    it;
    int unsigned gap;
    it.key      = k;
    it.last_key = lst;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    ledger.note_key(it);
    sent++;
    // A gap follows about one key in nine; its length is random.
    if (!(sent >= 200 && sent < 330) && $urandom_range(99) < 11) begin
      gap = $urandom_range(4, 1);
      start <= 1'b0;
      // Scramble the idle payload so a missed start qualification shows up.
      item  <= in_item_t'({$urandom, 1'($urandom)});
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mix of full-range keys, a narrow band that forces ties, and the extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: k = $urandom;
      5, 6:          k = int'($urandom_range(8)) - 4;
      7:             k = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      8:             k = 32'sh8000_0000 + int'($urandom_range(3));
      default:       k = 32'sh7fff_ffff - int'($urandom_range(3));
    endcase
    return k;
  endfunction

  // Send one data set of random keys; only the final key carries the last flag.
  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_key(pick_key(), i == len - 1);
  endtask

  initial begin
    int spins;
    int len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: a lone key closes its own set.
    send_key(32'sh7fff_ffff, 1'b1);
    // Extremes of the key range, across the sign boundary.
    send_key(32'sh8000_0000, 1'b0);
    send_key(32'sh7fff_ffff, 1'b0);
    send_key(32'sh0000_0000, 1'b0);
    send_key(-32'sd1,        1'b0);
    send_key(32'sh0000_0001, 1'b1);
    // Ties must keep arrival order.
    send_key(32'sd7,  1'b0);
    send_key(-32'sd3, 1'b0);
    send_key(32'sd7,  1'b0);
    send_key(32'sd7,  1'b0);
    send_key(-32'sd3, 1'b1);
    // All keys equal.
    send_key(32'sd0, 1'b0);
    send_key(32'sd0, 1'b0);
    send_key(32'sd0, 1'b1);
    // Strictly descending, then the most negative key last.
    send_key(32'sd3, 1'b0);
    send_key(32'sd2, 1'b0);
    send_key(32'sd1, 1'b0);
    send_key(32'sh8000_0000, 1'b1);

    // Capacity: a set that fills exactly, then one cut at the capacity so the
    // dropped keys include the one that closes the set.
    send_set(MAX_KEYS);
    send_set(MAX_KEYS + 3);

    // Random sets: mostly short, now and then around the capacity.
    while (sent < 518) begin
      len = ($urandom_range(99) < 8) ? $urandom_range(MAX_KEYS + 6, MAX_KEYS - 4)
                                     : $urandom_range(12, 1);
      send_set(len);
    end
    start <= 1'b0;

    // Drain: wait for the outstanding positions, then keep watching for stray results.
    spins = 0;
    while (ledger.due.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);
    if (ledger.due.size() != 0) begin
      $display("%0t: %0d expected results never arrived, next expected position %0d",
               $time, ledger.due.size(), ledger.due[0].position);
      ledger.errors++;
    end

    if (ledger.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop in case a transfer or a result never comes.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/ixs_pkg.sv
hdl/ixs_cell.sv
hdl/index_sort_core.sv
hdl/ixs_checker.sv
tb/sv/tb_top.sv
